>>> sv/serl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serl_pkg: shared types and constants for the rectangle lookup
// Holds the table size, the command codes, the stored entry record and the
// query token that travels along the row of cells.
// ---------------------------------------------------------------------------
package serl_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int AREA_W     = 2 * SIZE_W;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // One stored rectangle, with its area worked out when it is written.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [AREA_W-1:0]  area;
  } rect_t;

  // Query in flight: the point and the best match seen so far.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               found;
    logic [AREA_W-1:0]  area;
    logic [IDX_W-1:0]   idx;
  } token_t;

endpackage

>>> sv/smallest_enclosing_rect_lookup.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smallest_enclosing_rect_lookup: smallest enclosing rectangle hit test
// Keeps a table of rectangles and finds the smallest one holding a point.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising clock edge with start high and busy
//   low. in_kind selects append, clear or point query; in_pos_x/in_pos_y
//   carry the corner or the point, in_rect_width/in_rect_height the size.
//   Every transaction gives exactly one result, shown on the out_ ports for
//   one cycle with out_strobe high. The receiver cannot stall the block, so
//   a result is simply taken at the edge that ends its strobe cycle.
// Timing and issue rate:
//   Append, clear and the unused code answer in the cycle after acceptance
//   and busy stays low, so they can be issued every cycle. A query walks a
//   token down the row of MAX_BLOCKS cells, one cell per clock; busy stays
//   high until the result strobes, so no new command is taken while a query
//   is in flight. The length of the cell row sets how long a query holds
//   the block.
// Reset:
//   rst_n low empties the table and drops any query in flight. Entry
//   contents are not cleared; only slots below the count are ever compared.
// ---------------------------------------------------------------------------
module smallest_enclosing_rect_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [14:0] in_rect_width,
  input  logic [14:0] in_rect_height,
  output logic        out_strobe,
  output logic        out_found,
  output logic [3:0]  out_block_index,
  output logic [4:0]  out_block_count
);
  import serl_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic              out_found_r, out_found_nxt;
  logic [3:0]        out_index_r, out_index_nxt;
  logic [4:0]        out_count_r, out_count_nxt;

  logic              accept;
  logic              append_ok;
  rect_t             wr_rect;
  token_t            tok [0:MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tok_vld;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_SCAN);

  // An append is stored only for a nonempty rectangle while a slot is free.
  assign append_ok = accept && (in_kind == KIND_APPEND) &&
                     (in_rect_width != '0) && (in_rect_height != '0) &&
                     (count_r < CNT_W'(MAX_BLOCKS));

  // The area is multiplied once on the way in and kept with the entry.
  assign wr_rect.left   = in_pos_x;
  assign wr_rect.top    = in_pos_y;
  assign wr_rect.width  = in_rect_width;
  assign wr_rect.height = in_rect_height;
  assign wr_rect.area   = {{SIZE_W{1'b0}}, in_rect_width} *
                          {{SIZE_W{1'b0}}, in_rect_height};

  // A query launches a fresh token into the first cell at acceptance.
  assign tok[0].valid = accept && (in_kind == KIND_QUERY);
  assign tok[0].px    = in_pos_x;
  assign tok[0].py    = in_pos_y;
  assign tok[0].found = 1'b0;
  assign tok[0].area  = '0;
  assign tok[0].idx   = '0;

  // Each cell owns one slot; the token moves one cell per clock, and since
  // it visits slots in order, a later equal-area entry never wins.
  for (genvar gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
    serl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (append_ok && (count_r == CNT_W'(gi))),
      .wr_rect  (wr_rect),
      .live     (CNT_W'(gi) < count_r),
      .cell_idx (IDX_W'(gi)),
      .tok_in   (tok[gi]),
      .tok_out  (tok[gi+1])
    );
    assign tok_vld[gi] = tok[gi+1].valid;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = 1'b0;
    out_index_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (kind_t'(in_kind))
            KIND_APPEND: begin
              out_strobe_nxt = 1'b1;
              if (append_ok) begin
                count_nxt     = count_r + CNT_W'(1);
                out_found_nxt = 1'b1;
                out_index_nxt = 4'(count_r);
              end
            end
            KIND_CLEAR: begin
              out_strobe_nxt = 1'b1;
              count_nxt      = '0;
            end
            KIND_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              // The unused code leaves the table alone and reports the count.
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The token leaving the last cell carries the final answer.
        if (tok[MAX_BLOCKS].valid) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_found_nxt  = tok[MAX_BLOCKS].found;
          out_index_nxt  = tok[MAX_BLOCKS].found ? 4'(tok[MAX_BLOCKS].idx) : 4'd0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_count_nxt = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_found       = out_found_r;
  assign out_block_index = out_index_r;
  assign out_block_count = out_count_r;

  // At most one query token is ever in the cell row.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one query token in the cell row");

  // An accepted query holds the block busy on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // A clear answers next cycle with an empty table.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_CLEAR)) |=>
      (out_strobe && (out_block_count == 5'd0)))
    else $error("clear did not report an empty table");

  // A hit or a stored append implies a nonempty table.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |-> (out_block_count != 5'd0))
    else $error("match reported with an empty table");

endmodule

>>> sv/serl_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serl_cell: one table slot of the rectangle lookup
// Stores one rectangle. A passing query token takes it as best match if the
// slot is live, holds the point and is strictly smaller than any prior match.
// ---------------------------------------------------------------------------
module serl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  serl_pkg::rect_t wr_rect,
  input  logic            live,
  input  logic [serl_pkg::IDX_W-1:0] cell_idx,
  input  serl_pkg::token_t tok_in,
  output serl_pkg::token_t tok_out
);
  import serl_pkg::*;

  rect_t  rect_r;
  token_t tok_r;
  token_t tok_nxt;

  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic             hit;
  logic             better;

  // Offsets from the corner at one extra bit, so edges never wrap.
  assign dx = {tok_in.px[COORD_W-1], tok_in.px} - {rect_r.left[COORD_W-1], rect_r.left};
  assign dy = {tok_in.py[COORD_W-1], tok_in.py} - {rect_r.top[COORD_W-1], rect_r.top};

  assign hit = !dx[COORD_W] && (dx[COORD_W-1:0] < {1'b0, rect_r.width}) &&
               !dy[COORD_W] && (dy[COORD_W-1:0] < {1'b0, rect_r.height});

  assign better = live && hit && (!tok_in.found || (rect_r.area < tok_in.area));

  always_comb begin
    tok_nxt = tok_in;
    if (better) begin
      tok_nxt.found = 1'b1;
      tok_nxt.area  = rect_r.area;
      tok_nxt.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rect_r <= wr_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.px    <= tok_nxt.px;
    tok_r.py    <= tok_nxt.py;
    tok_r.found <= tok_nxt.found;
    tok_r.area  <= tok_nxt.area;
    tok_r.idx   <= tok_nxt.idx;
  end

  assign tok_out = tok_r;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the smallest enclosing rectangle lookup
// Drives append, clear, point query and unused commands into the block,
// keeps its own copy of the rectangle table to work out the expected answer
// for each command, and checks every strobed result against the oldest one.
// ---------------------------------------------------------------------------
module tb_top;
  import serl_pkg::*;

  // The two bit command field has one code the package does not name.
  // The block must answer it without touching the table.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // A query holds the block only while its token walks the cell row and
  // send_command bounds the sender's idle gaps, so a quiet stretch of this
  // length means the block has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * MAX_BLOCKS + 4;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
    logic [4:0] count;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_APPEND;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic [14:0] in_rect_width = '0;
  logic [14:0] in_rect_height = '0;
  logic        out_strobe;
  logic        out_found;
  logic [3:0]  out_block_index;
  logic [4:0]  out_block_count;

  // Our own copy of the rectangle table, updated as each transaction is
  // accepted. Only slots below stored_total are ever read.
  logic signed [15:0] rect_left   [MAX_BLOCKS];
  logic signed [15:0] rect_top    [MAX_BLOCKS];
  logic        [14:0] rect_width  [MAX_BLOCKS];
  logic        [14:0] rect_height [MAX_BLOCKS];
  int                 stored_total = 0;

  lookup_result_t expected_results[$];
  int             mismatch_count = 0;
  int             commands_sent = 0;
  int             idle_pct = 0;
  int             quiet_cycles = 0;

  smallest_enclosing_rect_lookup uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_block_index (out_block_index),
    .out_block_count (out_block_count)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow table and returns the answer the block
  // must give. Edges are inclusive and compared as full 32 bit integers, so a
  // rectangle reaching past the top of the coordinate range does not wrap.
  // On equal area the lower slot keeps the win because only a strictly
  // smaller area replaces the current best.
  function automatic lookup_result_t predict_lookup(input logic [1:0] kind,
                                                    input logic signed [15:0] px,
                                                    input logic signed [15:0] py,
                                                    input logic [14:0] w,
                                                    input logic [14:0] h);
    lookup_result_t res;
    logic [29:0]    area;
    logic [29:0]    best_area;
    int             px_i;
    int             py_i;
    int             lx;
    int             ty;
    int             i;
    res = '0;
    best_area = '0;
    px_i = int'(px);
    py_i = int'(py);
    case (kind)
      KIND_APPEND: begin
        if (w != 0 && h != 0 && stored_total < MAX_BLOCKS) begin
          rect_left[stored_total] = px;
          rect_top[stored_total] = py;
          rect_width[stored_total] = w;
          rect_height[stored_total] = h;
          res.found = 1'b1;
          res.index = stored_total[3:0];
          stored_total++;
        end
      end
      KIND_CLEAR: begin
        stored_total = 0;
      end
      KIND_QUERY: begin
        for (i = 0; i < stored_total; i++) begin
          lx = int'(rect_left[i]);
          ty = int'(rect_top[i]);
          if (px_i >= lx && px_i <= lx + int'(rect_width[i]) - 1 &&
              py_i >= ty && py_i <= ty + int'(rect_height[i]) - 1) begin
            area = 30'(rect_width[i]) * 30'(rect_height[i]);
            if (!res.found || area < best_area) begin
              best_area = area;
              res.index = i[3:0];
              res.found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.count = stored_total[4:0];
    return res;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Mostly small sizes so that rectangles overlap and areas tie, with some
  // full range sizes to exercise every bit and a few empty ones.
  function automatic int random_size();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 75) return $urandom_range(64, 1);
    if (r < 90) return $urandom_range(1024, 1);
    return $urandom_range(32767, 1);
  endfunction

  // Sends one transaction. An optional idle gap comes first, then start is
  // held with the fields until the block takes it at an edge with busy low.
  // Start is left high on return so back-to-back commands never see it drop;
  // the next call or the end of the test decides its next value, so it gets
  // only one assignment per clock edge.
  task automatic send_command(input logic [1:0] kind, input int x, input int y,
                              input int w, input int h);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(20, 1)) @(posedge clk);
      else
        repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_pos_x <= x[15:0];
    in_pos_y <= y[15:0];
    in_rect_width <= w[14:0];
    in_rect_height <= h[14:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_lookup(kind, x[15:0], y[15:0], w[14:0], h[14:0]));
    if (kind != KIND_UNUSED) commands_sent++;
  endtask

  // Queries against an empty table, empty rectangles and the unused command
  // code. None of these may store anything.
  task automatic test_empty_and_ignored();
    send_command(KIND_QUERY, 0, 0, 32767, 32767);
    send_command(KIND_APPEND, 100, 100, 0, 5);
    send_command(KIND_APPEND, 100, 100, 5, 0);
    send_command(KIND_UNUSED, -1, -1, 32767, 32767);
  endtask

  // Fills the table, including the two corner rectangles at the coordinate
  // extremes, a nested pair and an exact duplicate to check that the earlier
  // of two equal areas wins. One more append then hits the full table.
  task automatic test_full_table_and_ties();
    int i;
    send_command(KIND_APPEND, -32768, -32768, 32767, 32767);
    send_command(KIND_APPEND, 32767, 32767, 32767, 32767);
    send_command(KIND_APPEND, -10, -10, 21, 21);
    send_command(KIND_APPEND, -5, -5, 11, 11);
    send_command(KIND_APPEND, -5, -5, 11, 11);
    for (i = 5; i < MAX_BLOCKS; i++)
      send_command(KIND_APPEND, 1000 + 40 * i, -1000 - 40 * i, i, 32767 - i);
    send_command(KIND_APPEND, 0, 0, 1, 1);
    send_command(KIND_QUERY, 32767, 32767, 0, 0);
    send_command(KIND_QUERY, -32768, -32768, 0, 0);
    send_command(KIND_QUERY, 0, 0, 0, 0);
    send_command(KIND_QUERY, 5, 5, 0, 0);
    send_command(KIND_QUERY, 6, 5, 0, 0);
    send_command(KIND_QUERY, 11, 10, 0, 0);
  endtask

  task automatic test_clear();
    send_command(KIND_CLEAR, 32767, -32768, 32767, 32767);
    send_command(KIND_QUERY, 0, 0, 0, 0);
  endtask

  // One scene: usually start from a clear table, append a group of
  // rectangles most of which surround one anchor point, then query near the
  // anchor, inside stored rectangles, or anywhere. Skipping the clear lets
  // the table fill up across scenes.
  task automatic run_scene();
    int ax;
    int ay;
    int x;
    int y;
    int w;
    int h;
    int last_w;
    int last_h;
    int n;
    int j;
    int r;
    if ($urandom_range(3) != 0)
      send_command(KIND_CLEAR, random_coord(), random_coord(),
                   $urandom_range(32767), $urandom_range(32767));
    if ($urandom_range(1) == 0) begin
      ax = int'($urandom_range(400)) - 200;
      ay = int'($urandom_range(400)) - 200;
    end else begin
      ax = random_coord();
      ay = random_coord();
    end
    last_w = 1;
    last_h = 1;
    n = $urandom_range(18, 1);
    repeat (n) begin
      if ($urandom_range(5) == 0) begin
        // Same area as the previous rectangle, sides swapped.
        w = last_h;
        h = last_w;
      end else begin
        w = random_size();
        h = random_size();
      end
      if ($urandom_range(3) != 0) begin
        x = clamp_coord(ax - ((w > 0) ? int'($urandom_range(w - 1)) : 0));
        y = clamp_coord(ay - ((h > 0) ? int'($urandom_range(h - 1)) : 0));
      end else begin
        x = random_coord();
        y = random_coord();
      end
      send_command(KIND_APPEND, x, y, w, h);
      if (w != 0 && h != 0) begin
        last_w = w;
        last_h = h;
      end
      if ($urandom_range(49) == 0)
        send_command(KIND_UNUSED, random_coord(), random_coord(),
                     $urandom_range(32767), $urandom_range(32767));
    end
    n = $urandom_range(8, 2);
    repeat (n) begin
      r = $urandom_range(9);
      if (r < 5) begin
        x = clamp_coord(ax + int'($urandom_range(8)) - 4);
        y = clamp_coord(ay + int'($urandom_range(8)) - 4);
      end else if (r < 8 && stored_total > 0) begin
        j = $urandom_range(stored_total - 1);
        x = int'(rect_left[j]);
        y = int'(rect_top[j]);
        x = clamp_coord(x + int'($urandom_range(rect_width[j] - 1)));
        y = clamp_coord(y + int'($urandom_range(rect_height[j] - 1)));
      end else begin
        x = random_coord();
        y = random_coord();
      end
      // Width and height are meaningless for a query, so they carry noise.
      send_command(KIND_QUERY, x, y, $urandom_range(32767), $urandom_range(32767));
    end
  endtask

  task automatic test_random_traffic(input int n_commands, input int pct);
    int target;
    idle_pct = pct;
    target = commands_sent + n_commands;
    while (commands_sent < target) run_scene();
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Result checker. The receiver cannot stall the block, so every strobe is
  // one result transaction and is compared with the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, found %0d index %0d count %0d",
                 $time, out_found, out_block_index, out_block_count);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("found", int'(exp_res.found), int'(out_found));
        check_field("block_index", int'(exp_res.index), int'(out_block_index));
        check_field("block_count", int'(exp_res.count), int'(out_block_count));
      end
    end
  end

  // Watchdog: any accepted command or result clears the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_ignored();
    test_full_table_and_ties();
    test_clear();

    // Random traffic, first without gaps, then with a sender that idles
    // often, then with light idling.
    test_random_traffic(420, 0);
    test_random_traffic(420, 54);
    test_random_traffic(420, 20);

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/serl_pkg.sv
sv/serl_cell.sv
sv/smallest_enclosing_rect_lookup.sv
test/tb_top.sv
